>>> src/wsp_pkg.sv
// Package: shared types, constants and column rules of the write-hazard sync planner.
package wsp_pkg;

  // Sizing
  localparam int RESOURCES   = 256;
  localparam int MAX_COLUMNS = 16;
  localparam int ID_W        = 8;
  localparam int CNT_MAX_W   = 16;
  localparam int RES_AW      = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int CB_AW       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
  localparam logic [CNT_MAX_W-1:0] CNT_SAT = '1;

  // Source kinds
  localparam logic [1:0] SRC_OWN   = 2'd0;
  localparam logic [1:0] SRC_NONE  = 2'd1;
  localparam logic [1:0] SRC_OTHER = 2'd2;
  localparam logic [1:0] SRC_UNDEF = 2'd3;

  // Combine kinds
  localparam logic [1:0] COMB_AND   = 2'd0;
  localparam logic [1:0] COMB_OR    = 2'd1;
  localparam logic [1:0] COMB_NOT   = 2'd2;
  localparam logic [1:0] COMB_UNDEF = 2'd3;

  // Access kinds
  localparam logic [1:0] ACC_RW    = 2'd0;
  localparam logic [1:0] ACC_RD    = 2'd1;
  localparam logic [1:0] ACC_WR    = 2'd2;
  localparam logic [1:0] ACC_OTHER = 2'd3;

  // Write states of a table entry
  localparam logic [1:0] WS_NONE  = 2'd0;
  localparam logic [1:0] WS_MAIN  = 2'd1;
  localparam logic [1:0] WS_STAGE = 2'd2;

  // Input beat
  typedef struct packed {
    logic [ID_W-1:0] resource_id;
    logic [1:0]      source_kind;
    logic [1:0]      combine_kind;
    logic [1:0]      access_kind;
    logic            task_active;
    logic            column_present;
    logic            last_column;
  } in_t;

  // Result beat
  typedef struct packed {
    logic                 sync_before;
    logic [CNT_MAX_W-1:0] group_index;
    logic [CNT_MAX_W-1:0] group_active_count;
    logic                 column_overflow;
  } res_t;

  // Normalized column as kept in the column buffer
  typedef struct packed {
    logic [1:0]      acc;
    logic [1:0]      comb;
    logic [1:0]      src;
    logic [ID_W-1:0] res;
  } col_t;

  localparam int COL_W = $bits(col_t);

  // Outcome of one column against the table
  typedef struct packed {
    logic       hazard;
    logic       we;
    logic [1:0] wval;
  } apply_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // capture beat, read table at its resource
    logic col_eval;    // apply captured column, buffer it
    logic sync_clear;  // clear the table, restart replay index
    logic cbuf_rd;     // read buffered column at replay index
    logic tab_rd_rp;   // read table at the replayed column's resource
    logic rp_eval;     // apply replayed column, advance index
    logic emit;        // load result, update group counters
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_present;
    logic in_last;
    logic last_q;
    logic active_q;
    logic sync_q;
    logic rp_more;
    logic out_free;
  } sts_t;

  // Map undefined codes onto their defined behavior
  function automatic col_t norm_col(in_t b);
    col_t c;
    c.res  = b.resource_id;
    c.src  = (b.source_kind == SRC_UNDEF) ? SRC_OTHER : b.source_kind;
    c.comb = (b.combine_kind == COMB_UNDEF) ? COMB_AND : b.combine_kind;
    c.acc  = b.access_kind;
    return c;
  endfunction

  function automatic logic res_in_range(logic [ID_W-1:0] id);
    return int'(id) < RESOURCES;
  endfunction

  // Column rules against the current write state of its resource
  function automatic apply_t apply_col(col_t c, logic active, logic [1:0] ws);
    apply_t r;
    logic   writes;
    r      = '0;
    writes = (c.acc == ACC_RW) || (c.acc == ACC_WR);
    if (c.comb != COMB_OR) begin
      if (c.src == SRC_OWN && c.comb != COMB_NOT) begin
        if ((c.acc == ACC_RW || c.acc == ACC_RD) && ws == WS_STAGE) begin
          r.hazard = 1'b1;
        end else if (writes && active) begin
          r.we   = 1'b1;
          r.wval = WS_MAIN;
        end
      end else if (c.src == SRC_NONE || c.comb == COMB_NOT) begin
        if (writes && active) begin
          r.we   = 1'b1;
          r.wval = WS_STAGE;
        end
      end
    end
    return r;
  endfunction

endpackage

>>> src/wsp_col_if.sv
// Interface: input column channel with valid/ready handshake.
interface wsp_col_if;
  import wsp_pkg::*;

  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/wsp_res_if.sv
// Interface: result channel with valid/ready handshake.
interface wsp_res_if;
  import wsp_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/wsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/wsp_ctrl.sv
// Controller: sequences column updates, sync clear, replay and result hand-off.
module wsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  wsp_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output wsp_pkg::cmd_t cmd_o
);
  import wsp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_RP_A = 3'd3;
  localparam logic [2:0] ST_RP_C = 3'd4;
  localparam logic [2:0] ST_RP_T = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_present) begin
            state_d = ST_EVAL;
          end else if (sts_i.in_last) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_EVAL: begin
        cmd_o.col_eval = 1'b1;
        state_d = sts_i.last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (sts_i.sync_q) begin
          cmd_o.sync_clear = 1'b1;
          state_d = sts_i.active_q ? ST_RP_A : ST_DONE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RP_A: begin
        if (sts_i.rp_more) begin
          cmd_o.cbuf_rd = 1'b1;
          state_d = ST_RP_C;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RP_C: begin
        cmd_o.tab_rd_rp = 1'b1;
        state_d = ST_RP_T;
      end
      ST_RP_T: begin
        cmd_o.rp_eval = 1'b1;
        state_d = ST_RP_A;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/wsp_dp.sv
// Datapath: write-state table, column buffer, group counters and result register.
module wsp_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wsp_pkg::in_t  col_i,
  input  wsp_pkg::cmd_t cmd_i,
  input  logic          res_ready_i,
  output wsp_pkg::sts_t sts_o,
  output logic          res_valid_o,
  output wsp_pkg::res_t res_o
);
  import wsp_pkg::*;

  // Captured beat
  col_t col_q;
  logic active_q;
  logic last_q;

  // Task and group state
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     rp_idx_q, rp_idx_d;
  logic                 ovf_q, ovf_d;
  logic                 sync_q, sync_d;
  logic                 open_q, open_d;
  logic [CNT_MAX_W-1:0] grp_q, grp_d;
  logic [CNT_MAX_W-1:0] act_q, act_d;
  logic [RESOURCES-1:0] tvalid_q, tvalid_d;

  // Result register
  logic res_valid_q, res_valid_d;
  res_t res_q;

  // Memory ports
  logic              tab_re;
  logic [RES_AW-1:0] tab_raddr;
  logic              tab_we;
  logic [1:0]        tab_rdata;
  logic              cb_we;
  logic [COL_W-1:0]  cb_rdata;
  col_t              cb_col;
  col_t              in_col;

  // Column under evaluation
  col_t              ev_col;
  logic [RES_AW-1:0] ev_addr;
  logic              ev_in;
  logic              ev_active;
  logic [1:0]        ev_ws;
  apply_t            ap;

  assign in_col = norm_col(col_i);
  assign cb_col = col_t'(cb_rdata);

  // Table read: at accept from the beat, during replay from the buffer
  assign tab_re    = cmd_i.accept || cmd_i.tab_rd_rp;
  assign tab_raddr = cmd_i.accept ? RES_AW'(in_col.res) : RES_AW'(cb_col.res);

  // Evaluate the captured or replayed column
  assign ev_col    = cmd_i.rp_eval ? cb_col : col_q;
  assign ev_addr   = RES_AW'(ev_col.res);
  assign ev_in     = res_in_range(ev_col.res);
  assign ev_active = cmd_i.rp_eval ? 1'b1 : active_q;
  assign ev_ws     = (ev_in && tvalid_q[ev_addr]) ? tab_rdata : WS_NONE;
  assign ap        = apply_col(ev_col, ev_active, ev_ws);
  assign tab_we    = (cmd_i.col_eval || cmd_i.rp_eval) && ap.we && ev_in;

  // Buffer a column while there is room
  assign cb_we = cmd_i.col_eval && (int'(cnt_q) < MAX_COLUMNS);

  wsp_ram #(
    .Width (2),
    .Depth (RESOURCES)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (ev_addr),
    .wdata_i (ap.wval),
    .re_i    (tab_re),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  wsp_ram #(
    .Width (COL_W),
    .Depth (MAX_COLUMNS)
  ) u_cbuf_ram (
    .clk_i   (clk_i),
    .we_i    (cb_we),
    .waddr_i (cnt_q[CB_AW-1:0]),
    .wdata_i (col_q),
    .re_i    (cmd_i.cbuf_rd),
    .raddr_i (rp_idx_q[CB_AW-1:0]),
    .rdata_o (cb_rdata)
  );

  // Next values of task, table-valid and group state
  always_comb begin
    cnt_d       = cnt_q;
    rp_idx_d    = rp_idx_q;
    ovf_d       = ovf_q;
    sync_d      = sync_q;
    open_d      = open_q;
    grp_d       = grp_q;
    act_d       = act_q;
    tvalid_d    = tvalid_q;
    res_valid_d = res_valid_q;

    if (res_ready_i) begin
      res_valid_d = 1'b0;
    end

    if (cmd_i.col_eval) begin
      if (ap.hazard) begin
        sync_d = 1'b1;
      end
      if (cb_we) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (tab_we) begin
      tvalid_d[ev_addr] = 1'b1;
    end

    if (cmd_i.sync_clear) begin
      tvalid_d = '0;
      rp_idx_d = '0;
    end

    if (cmd_i.rp_eval) begin
      rp_idx_d = rp_idx_q + CNT_W'(1);
    end

    // Close the task: advance group, count active tasks
    if (cmd_i.emit) begin
      if (sync_q) begin
        if (open_q) begin
          if (grp_q != CNT_SAT) begin
            grp_d = grp_q + CNT_MAX_W'(1);
          end
        end else begin
          open_d = 1'b1;
          grp_d  = '0;
        end
        act_d = '0;
      end else if (!open_q) begin
        open_d = 1'b1;
        grp_d  = '0;
        act_d  = '0;
      end
      if (active_q && act_d != CNT_SAT) begin
        act_d = act_d + CNT_MAX_W'(1);
      end
      cnt_d       = '0;
      ovf_d       = 1'b0;
      sync_d      = 1'b0;
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rp_idx_q    <= '0;
      ovf_q       <= 1'b0;
      sync_q      <= 1'b0;
      open_q      <= 1'b0;
      grp_q       <= '0;
      act_q       <= '0;
      tvalid_q    <= '0;
      res_valid_q <= 1'b0;
      last_q      <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rp_idx_q    <= rp_idx_d;
      ovf_q       <= ovf_d;
      sync_q      <= sync_d;
      open_q      <= open_d;
      grp_q       <= grp_d;
      act_q       <= act_d;
      tvalid_q    <= tvalid_d;
      res_valid_q <= res_valid_d;
      if (cmd_i.accept) begin
        last_q   <= col_i.last_column;
        active_q <= col_i.task_active;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_q <= in_col;
    end
    if (cmd_i.emit) begin
      res_q.sync_before        <= sync_q;
      res_q.group_index        <= grp_d;
      res_q.group_active_count <= act_d;
      res_q.column_overflow    <= ovf_q;
    end
  end

  assign sts_o.in_present = col_i.column_present;
  assign sts_o.in_last    = col_i.last_column;
  assign sts_o.last_q     = last_q;
  assign sts_o.active_q   = active_q;
  assign sts_o.sync_q     = sync_q;
  assign sts_o.rp_more    = (rp_idx_q < cnt_q);
  assign sts_o.out_free   = !res_valid_q || res_ready_i;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> src/write_hazard_sync_planner.sv
// Top level: write-hazard sync planner, controller plus datapath.
//
//   channel | dir | beat                                  | when
//   col_i   | in  | one access column of a task           | valid && ready
//   res_o   | out | sync flag, group index, active count  | valid && ready, last column
//
// A column is accepted with the table read issued, then updated in ST_EVAL via
// the table RAM's registered read port. A task's close runs ST_FIN and ST_DONE,
// with ST_RP_A/C/T per buffered column when a sync replays an active task.
// Reset clears the table at once through per-entry valid bits; no clearing pass.
// New columns are taken while a result waits; a close stalls until the
// result register is free.
module write_hazard_sync_planner (
  input logic clk_i,
  input logic rst_ni,
  wsp_col_if.sink   col_i,
  wsp_res_if.source res_o
);
  import wsp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  wsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (col_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  wsp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_i       (col_i.data),
    .cmd_i       (cmd),
    .res_ready_i (res_o.ready),
    .sts_o       (sts),
    .res_valid_o (res_o.valid),
    .res_o       (res_o.data)
  );

  assign col_i.ready = in_ready;

endmodule

>>> bench/wsp_plan_checker.sv
// Checker: predicts each task's sync plan from column beats and compares result beats.
`timescale 1ns / 100ps

module wsp_plan_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          col_valid_i,
  input  logic          col_ready_i,
  input  wsp_pkg::in_t  col_beat_i,
  input  logic          res_valid_i,
  input  logic          res_ready_i,
  input  wsp_pkg::res_t res_beat_i,
  output int            fail_count_o,
  output int            plans_waiting_o
);
  import wsp_pkg::*;

  // Predicted planner state
  logic [1:0]           wr_state [RESOURCES];
  col_t                 col_log [MAX_COLUMNS];
  int unsigned          col_count;
  logic                 col_spill;
  logic                 sync_need;
  logic                 group_started;
  logic [CNT_MAX_W-1:0] group_idx;
  logic [CNT_MAX_W-1:0] group_actives;
  res_t                 plan_q[$];
  int                   fails;

  // Apply one normalized column to the write-state table; return 1 on a stage read
  function automatic logic touch_table(input col_t c, input logic act);
    logic       writes;
    logic       hit;
    logic [1:0] cur;
    logic [1:0] nxt;
    logic       upd;
    writes = (c.acc == ACC_RW) || (c.acc == ACC_WR);
    cur    = (int'(c.res) < RESOURCES) ? wr_state[c.res] : WS_NONE;
    hit    = 1'b0;
    upd    = 1'b0;
    nxt    = cur;
    if (c.comb != COMB_OR) begin
      if (c.src == SRC_OWN && c.comb != COMB_NOT) begin
        if ((c.acc == ACC_RW || c.acc == ACC_RD) && cur == WS_STAGE) begin
          hit = 1'b1;
        end else if (writes && act) begin
          upd = 1'b1;
          nxt = WS_MAIN;
        end
      end else if (c.src == SRC_NONE || c.comb == COMB_NOT) begin
        upd = writes && act;
        nxt = WS_STAGE;
      end
    end
    // Drop writes to ids beyond the table
    if (upd && int'(c.res) < RESOURCES) wr_state[c.res] = nxt;
    return hit;
  endfunction

  // Advance the prediction by one accepted column beat
  task automatic plan_beat(input in_t b);
    col_t c;
    res_t r;
    c.res  = b.resource_id;
    c.src  = (b.source_kind == SRC_UNDEF) ? SRC_OTHER : b.source_kind;
    c.comb = (b.combine_kind == COMB_UNDEF) ? COMB_AND : b.combine_kind;
    c.acc  = b.access_kind;
    if (b.column_present) begin
      if (touch_table(c, b.task_active)) sync_need = 1'b1;
      if (col_count < MAX_COLUMNS) begin
        col_log[col_count] = c;
        col_count++;
      end else begin
        col_spill = 1'b1;
      end
    end
    if (b.last_column) begin
      r.sync_before = sync_need;
      if (sync_need) begin
        // Clear the table, replay an active task, hazards found in replay are moot
        foreach (wr_state[i]) wr_state[i] = WS_NONE;
        if (b.task_active) begin
          for (int k = 0; k < int'(col_count); k++) void'(touch_table(col_log[k], 1'b1));
        end
        if (!group_started) begin
          group_started = 1'b1;
          group_idx     = '0;
        end else if (group_idx != CNT_SAT) begin
          group_idx++;
        end
        group_actives = '0;
      end else if (!group_started) begin
        group_started = 1'b1;
        group_idx     = '0;
        group_actives = '0;
      end
      if (b.task_active && group_actives != CNT_SAT) group_actives++;
      r.group_index        = group_idx;
      r.group_active_count = group_actives;
      r.column_overflow    = col_spill;
      plan_q.push_back(r);
      col_count = 0;
      col_spill = 1'b0;
      sync_need = 1'b0;
    end
  endtask

  // Compare one result field; quiet after the first hundred mismatches
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (fails < 100) $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // Track column beats and check result beats against the oldest plan
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      foreach (wr_state[i]) wr_state[i] = WS_NONE;
      col_count     = 0;
      col_spill     = 1'b0;
      sync_need     = 1'b0;
      group_started = 1'b0;
      group_idx     = '0;
      group_actives = '0;
      plan_q.delete();
      fails         = 0;
    end else begin
      if (col_valid_i && col_ready_i) plan_beat(col_beat_i);
      if (res_valid_i && res_ready_i) begin
        if (plan_q.size() == 0) begin
          if (fails < 100) $error("result beat with no planned task waiting");
          fails++;
        end else begin
          want = plan_q.pop_front();
          check_field("sync_before", int'(want.sync_before),
                      int'(res_beat_i.sync_before));
          check_field("group_index", int'(want.group_index),
                      int'(res_beat_i.group_index));
          check_field("group_active_count", int'(want.group_active_count),
                      int'(res_beat_i.group_active_count));
          check_field("column_overflow", int'(want.column_overflow),
                      int'(res_beat_i.column_overflow));
        end
      end
    end
    fail_count_o    = fails;
    plans_waiting_o = plan_q.size();
  end

endmodule

>>> bench/write_hazard_sync_planner_test.sv
// Testbench top: drives column beats into the sync planner and gives the verdict.
`timescale 1ns / 100ps

module write_hazard_sync_planner_test;
  import wsp_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fails;
  int   waiting;
  int   src_idle_pct;
  int   sink_idle_pct;
  logic burst_armed;
  int   items_sent;

  wsp_col_if col_if ();
  wsp_res_if res_if ();

  write_hazard_sync_planner dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .col_i  (col_if),
    .res_o  (res_if)
  );

  wsp_plan_checker plan_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .col_valid_i     (col_if.valid),
    .col_ready_i     (col_if.ready),
    .col_beat_i      (col_if.data),
    .res_valid_i     (res_if.valid),
    .res_ready_i     (res_if.ready),
    .res_beat_i      (res_if.data),
    .fail_count_o    (fails),
    .plans_waiting_o (waiting)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off once armed
  initial begin : sink_side
    bit spent;
    spent        = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (burst_armed && !spent) begin
        res_if.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        spent = 1'b1;
      end
      res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offer one column beat and hold it until accepted; returns at a falling edge
  task automatic put_column(input logic [ID_W-1:0] id, input logic [1:0] src,
                            input logic [1:0] comb, input logic [1:0] acc,
                            input logic act, input logic pres, input logic last);
    in_t beat;
    beat.resource_id    = id;
    beat.source_kind    = src;
    beat.combine_kind   = comb;
    beat.access_kind    = acc;
    beat.task_active    = act;
    beat.column_present = pres;
    beat.last_column    = last;
    while ($urandom_range(99) < src_idle_pct) begin
      col_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    col_if.valid <= 1'b1;
    col_if.data  <= beat;
    @(posedge clk_i);
    while (!col_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every planned result has come back
  task automatic drain_plans();
    col_if.valid <= 1'b0;
    do @(negedge clk_i); while (waiting != 0);
  endtask

  // One random task: mostly short, sometimes past the column buffer
  task automatic random_task();
    int ncols;
    ncols = ($urandom_range(19) == 0) ? int'($urandom_range(19, 17))
                                      : int'($urandom_range(5, 1));
    for (int k = 0; k < ncols; k++) begin
      put_column(ID_W'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7)),
                 2'($urandom_range(3)),
                 ($urandom_range(9) < 6) ? COMB_AND : 2'($urandom_range(3)),
                 2'($urandom_range(3)),
                 $urandom_range(4) != 0,
                 $urandom_range(9) != 0,
                 k == ncols - 1);
    end
  endtask

  // Random tasks up to a beat budget under one idle mix
  task automatic random_phase(input int src_pct, input int sink_pct, input int beats);
    int stop_at;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at       = items_sent + beats;
    while (items_sent < stop_at) random_task();
    drain_plans();
  endtask

  // Stimulus
  initial begin
    rst_ni        = 1'b0;
    col_if.valid  = 1'b0;
    col_if.data   = '0;
    src_idle_pct  = 30;
    sink_idle_pct = 62;
    burst_armed   = 1'b0;
    items_sent    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Very first task needs a sync: opens group 0, replay hits a hazard again
    put_column(8'hFF, SRC_NONE, COMB_AND, ACC_WR, 1'b1, 1'b1, 1'b0);
    put_column(8'hFF, SRC_OWN, COMB_AND, ACC_RD, 1'b1, 1'b1, 1'b1);
    // Or-group and undefined source have no effect; not-combine stages
    put_column(8'hFF, SRC_OWN, COMB_OR, ACC_RW, 1'b1, 1'b1, 1'b0);
    put_column(8'hFF, SRC_UNDEF, COMB_AND, ACC_RW, 1'b1, 1'b1, 1'b0);
    put_column(8'h00, SRC_OWN, COMB_NOT, ACC_WR, 1'b1, 1'b1, 1'b0);
    put_column(8'h00, SRC_OWN, COMB_AND, ACC_OTHER, 1'b1, 1'b1, 1'b1);
    // Task with no column, inactive
    put_column(8'h00, SRC_OWN, COMB_AND, ACC_RW, 1'b0, 1'b0, 1'b1);
    // Undefined combine reads the staged entry: sync, inactive so no replay
    put_column(8'h00, SRC_OWN, COMB_UNDEF, ACC_RW, 1'b0, 1'b1, 1'b1);
    put_column(8'h5A, SRC_NONE, COMB_AND, ACC_RW, 1'b0, 1'b1, 1'b1);
    // Overflowing task with a hazard; its spilled column is not replayed
    put_column(8'hA5, SRC_NONE, COMB_AND, ACC_RW, 1'b1, 1'b1, 1'b0);
    for (int k = 1; k < MAX_COLUMNS - 1; k++) begin
      put_column(ID_W'(k * 17), SRC_OWN, COMB_AND, ACC_WR, 1'b1, 1'b1, 1'b0);
    end
    put_column(8'hA5, SRC_OWN, COMB_AND, ACC_RW, 1'b1, 1'b1, 1'b0);
    put_column(8'h80, SRC_NONE, COMB_NOT, ACC_WR, 1'b1, 1'b1, 1'b1);
    put_column(8'h80, SRC_OWN, COMB_AND, ACC_RD, 1'b1, 1'b1, 1'b1);
    drain_plans();

    // Random traffic under three idle mixes; long result hold-off in the last
    random_phase(30, 62, 140);
    random_phase(62, 30, 140);
    burst_armed = 1'b1;
    random_phase(0, 0, 140);

    // Let stray results surface, then judge
    repeat (100) @(negedge clk_i);
    if (fails == 0 && waiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/wsp_pkg.sv
src/wsp_col_if.sv
src/wsp_res_if.sv
src/wsp_ram.sv
src/wsp_ctrl.sv
src/wsp_dp.sv
src/write_hazard_sync_planner.sv
bench/wsp_plan_checker.sv
bench/write_hazard_sync_planner_test.sv
